// ===== rtl/motion_triggered_motor_controller_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef MOTION_TRIGGERED_MOTOR_CONTROLLER_MACROS_SVH
`define MOTION_TRIGGERED_MOTOR_CONTROLLER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MTMC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtmc: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define MTMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtmc: next-cycle check failed");

`endif

// ===== rtl/mtmc_pkg.sv =====
`timescale 1ns / 1ps
package mtmc_pkg;

	localparam int WINDOW_LEN_DEF = 20;

	localparam int CNT_W      = 16;
	localparam int THR_W      = 21;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	// Register reset values
	localparam logic [THR_W-1:0] THRESH_RST  = THR_W'(718200);
	localparam logic [CNT_W-1:0] RUN_RST     = CNT_W'(200);
	localparam logic [CNT_W-1:0] LOCKOUT_RST = CNT_W'(1000);
	localparam logic [CNT_W-1:0] PREDICT_RST = CNT_W'(50);
	localparam logic [CNT_W-1:0] TEMP_RST    = CNT_W'(100);
	localparam logic [CNT_W-1:0] COLD_RST    = CNT_W'(12800);
	localparam logic [CNT_W-1:0] HOT_RST     = CNT_W'(14000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCORE_THRESHOLD = 3'd0,
		CFG_RUN_TICKS       = 3'd1,
		CFG_LOCKOUT_TICKS   = 3'd2,
		CFG_PREDICT_PERIOD  = 3'd3,
		CFG_TEMP_PERIOD     = 3'd4,
		CFG_COLD_LIMIT      = 3'd5,
		CFG_HOT_LIMIT       = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LED_RED   = 2'd0,
		LED_GREEN = 2'd1,
		LED_BLUE  = 2'd2
	} led_t;

	typedef struct packed {
		logic [THR_W-1:0] score_threshold;
		logic [CNT_W-1:0] run_ticks;
		logic [CNT_W-1:0] lockout_ticks;
		logic [CNT_W-1:0] predict_period;
		logic [CNT_W-1:0] temp_period;
		logic [CNT_W-1:0] cold_limit;
		logic [CNT_W-1:0] hot_limit;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic tick;
		logic scan;
		logic mul1;
		logic mul2;
		logic cmp;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} sts_t;

endpackage

// ===== rtl/mtmc_regs.sv =====
`timescale 1ns / 1ps
module mtmc_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mtmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtmc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mtmc_pkg::cfg_t                     cfg
);

	mtmc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= mtmc_pkg::THRESH_RST;
			cfg_q.run_ticks       <= mtmc_pkg::RUN_RST;
			cfg_q.lockout_ticks   <= mtmc_pkg::LOCKOUT_RST;
			cfg_q.predict_period  <= mtmc_pkg::PREDICT_RST;
			cfg_q.temp_period     <= mtmc_pkg::TEMP_RST;
			cfg_q.cold_limit      <= mtmc_pkg::COLD_RST;
			cfg_q.hot_limit       <= mtmc_pkg::HOT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mtmc_pkg::CFG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data;
				mtmc_pkg::CFG_RUN_TICKS:       cfg_q.run_ticks <= cfg_data[15:0];
				mtmc_pkg::CFG_LOCKOUT_TICKS:   cfg_q.lockout_ticks <= cfg_data[15:0];
				mtmc_pkg::CFG_PREDICT_PERIOD:  cfg_q.predict_period <= cfg_data[15:0];
				mtmc_pkg::CFG_TEMP_PERIOD:     cfg_q.temp_period <= cfg_data[15:0];
				mtmc_pkg::CFG_COLD_LIMIT:      cfg_q.cold_limit <= cfg_data[15:0];
				mtmc_pkg::CFG_HOT_LIMIT:       cfg_q.hot_limit <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/mtmc_ctrl.sv =====
`timescale 1ns / 1ps
module mtmc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  mtmc_pkg::sts_t sts,
	output mtmc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_MUL1,
		ST_MUL2,
		ST_CMP,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// Take a tick only when the result slot is free or frees at this edge
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.tick   = accept;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.mul1   = (state_q == ST_MUL1);
	assign cmd.mul2   = (state_q == ST_MUL2);
	assign cmd.cmp    = (state_q == ST_CMP);
	assign cmd.finish = (state_q == ST_FINISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= sts.need_scan ? ST_SCAN : ST_FINISH;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_MUL1;
				end
				ST_MUL1:   state_q <= ST_MUL2;
				ST_MUL2:   state_q <= ST_CMP;
				ST_CMP:    state_q <= ST_FINISH;
				ST_FINISH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/mtmc_datapath.sv =====
`timescale 1ns / 1ps
module mtmc_datapath #(
	parameter int WINDOW_LEN = mtmc_pkg::WINDOW_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtmc_pkg::cfg_t                cfg,
	input  mtmc_pkg::cmd_t                cmd,
	output mtmc_pkg::sts_t                sts,
	input  logic                          motion,
	input  logic                          smoke,
	input  logic [mtmc_pkg::CNT_W-1:0]    temperature,
	output logic                          motor_run,
	output logic                          lockout_active,
	output logic                          fast_mode,
	output logic [1:0]                    led_colour
);

	localparam int N = WINDOW_LEN;

	localparam longint W_MEAN  = 10 * N * (N - 1);
	localparam longint W_VAR   = 3 * (N + 1) * (N - 1);
	localparam longint W_TRANS = 2 * N * N * (N + 1);
	localparam longint S_MAX   = N * (N + 1) / 2;
	localparam longint KK_MAX  = (N / 2) * (N - N / 2);
	localparam longint SC_MAX  = W_MEAN * S_MAX + W_VAR * KK_MAX + W_TRANS * (N - 1);

	localparam int JW   = $clog2(N);
	localparam int FW   = $clog2(N + 1);
	localparam int KW   = $clog2(N + 1);
	localparam int SW   = $clog2(S_MAX + 1);
	localparam int TW   = $clog2(N);
	localparam int P1W  = $clog2(W_MEAN * S_MAX + 1);
	localparam int P2AW = $clog2(KK_MAX + 1);
	localparam int P2W  = $clog2(W_VAR * KK_MAX + 1);
	localparam int P3W  = $clog2(W_TRANS * (N - 1) + 1);
	localparam int SCW  = $clog2(SC_MAX + 1);
	localparam int CW   = (SCW > mtmc_pkg::THR_W) ? SCW : mtmc_pkg::THR_W;

	localparam int CNT_W = mtmc_pkg::CNT_W;

	// Tick state
	logic [N-1:0]       window_q;
	logic [FW-1:0]      fill_q;
	logic [CNT_W-1:0]   lockout_q;
	logic [CNT_W-1:0]   run_q;
	logic [CNT_W-1:0]   predict_q;
	logic [CNT_W-1:0]   temp_cnt_q;
	logic               fast_q;
	mtmc_pkg::led_t     led_q;
	logic               need_scan_q;
	logic               reload_q;

	// Score working registers
	logic [N-1:0]       scan_q;
	logic [JW-1:0]      j_q;
	logic [SW-1:0]      s_q;
	logic [KW-1:0]      k_q;
	logic [TW-1:0]      t_q;
	logic [P1W-1:0]     p1_q;
	logic [P2AW-1:0]    p2a_q;
	logic [P2W-1:0]     p2_q;
	logic [P3W-1:0]     p3_q;

	// Tick next values
	logic [CNT_W-1:0]   lock_dec;
	logic [CNT_W-1:0]   lock_n;
	logic [CNT_W-1:0]   run_n;
	logic [N-1:0]       window_n;
	logic [FW-1:0]      fill_n;
	logic [CNT_W-1:0]   temp_inc;
	logic               temp_fire;
	logic [CNT_W-1:0]   pred_inc;
	logic               pred_fire;
	logic               full_n;

	logic               scan_last;
	logic [SW-1:0]      rank;
	logic [KW-1:0]      k_rest;
	logic [CW-1:0]      score;
	logic [CNT_W-1:0]   run_r;
	logic [CNT_W-1:0]   run_f;

	always_comb begin
		lock_dec  = (lockout_q != '0) ? lockout_q - 1'b1 : lockout_q;
		lock_n    = smoke ? cfg.lockout_ticks : lock_dec;
		run_n     = smoke ? '0 : run_q;
		window_n  = {window_q[N-2:0], motion};
		fill_n    = (fill_q < FW'(N)) ? fill_q + 1'b1 : fill_q;
		full_n    = (fill_n == FW'(N));
		temp_inc  = temp_cnt_q + 1'b1;
		temp_fire = (temp_inc >= cfg.temp_period);
		pred_inc  = predict_q + 1'b1;
		pred_fire = (lock_n == '0) && (pred_inc >= cfg.predict_period);
	end

	assign scan_last     = (j_q == JW'(N - 1));
	assign rank          = SW'(N) - SW'(j_q);
	assign k_rest        = KW'(N) - k_q;
	assign score         = CW'(p1_q) + CW'(p2_q) + CW'(p3_q);
	assign sts.need_scan = need_scan_q;
	assign sts.scan_last = scan_last;

	// End of tick: optional reload, then count the run timer down
	assign run_r = reload_q ? cfg.run_ticks : run_q;
	assign run_f = (run_r != '0) ? run_r - 1'b1 : run_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			fill_q      <= '0;
			lockout_q   <= '0;
			run_q       <= '0;
			predict_q   <= '0;
			temp_cnt_q  <= '0;
			fast_q      <= 1'b0;
			led_q       <= mtmc_pkg::LED_GREEN;
			need_scan_q <= 1'b0;
			reload_q    <= 1'b0;
		end else begin
			if (cmd.tick) begin
				lockout_q <= lock_n;
				run_q     <= run_n;
				window_q  <= window_n;
				fill_q    <= fill_n;
				if (temp_fire) begin
					temp_cnt_q <= '0;
					fast_q     <= (temperature < cfg.cold_limit);
					if (temperature < cfg.cold_limit) begin
						led_q <= mtmc_pkg::LED_RED;
					end else if (temperature > cfg.hot_limit) begin
						led_q <= mtmc_pkg::LED_BLUE;
					end else begin
						led_q <= mtmc_pkg::LED_GREEN;
					end
				end else begin
					temp_cnt_q <= temp_inc;
				end
				if (lock_n != '0) begin
					predict_q <= '0;
				end else begin
					predict_q <= pred_fire ? '0 : pred_inc;
				end
				need_scan_q <= pred_fire && full_n;
				// Window not yet full scores zero
				reload_q    <= pred_fire && !full_n && (cfg.score_threshold == '0);
			end else if (cmd.cmp) begin
				reload_q <= (score >= CW'(cfg.score_threshold));
			end else if (cmd.finish) begin
				run_q <= run_f;
			end
		end
	end

	// Score pass over the window, oldest sample last, then the products
	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			scan_q <= window_n;
			j_q    <= '0;
			s_q    <= '0;
			k_q    <= '0;
			t_q    <= '0;
		end else if (cmd.scan) begin
			scan_q <= scan_q >> 1;
			j_q    <= j_q + 1'b1;
			if (scan_q[0]) begin
				s_q <= s_q + rank;
				k_q <= k_q + 1'b1;
			end
			if (!scan_last && (scan_q[0] != scan_q[1])) begin
				t_q <= t_q + 1'b1;
			end
		end
		if (cmd.mul1) begin
			p1_q  <= P1W'(s_q) * P1W'(W_MEAN);
			p2a_q <= P2AW'(k_q) * P2AW'(k_rest);
			p3_q  <= P3W'(t_q) * P3W'(W_TRANS);
		end
		if (cmd.mul2) begin
			p2_q <= P2W'(p2a_q) * P2W'(W_VAR);
		end
		if (cmd.finish) begin
			motor_run      <= (run_f != '0) && (lockout_q == '0);
			lockout_active <= (lockout_q != '0);
			fast_mode      <= fast_q;
			led_colour     <= led_q;
		end
	end

endmodule

// ===== rtl/motion_triggered_motor_controller.sv =====
`timescale 1ns / 1ps
// Channel   Role    Width  Beat contents
// s_*       in      24     one sensor tick: motion, smoke, temperature
// m_*       out     8      one status result per tick
// cfg_*     in      3+21   register write: index and value
//
// A tick with no prediction, or with a window not yet full, steps through accept, check and finish.
// A tick whose prediction finds a full window steps through accept, check,
// scan, mul1, mul2, cmp and finish: the score scans one window sample per cycle.
// Reset clears all timers, the window and the counters; the LED starts green.
// A result waits in the output register; the next tick is taken in the cycle
// that result is taken, or at once if the register is empty.
module motion_triggered_motor_controller #(
	parameter int WINDOW_LEN = mtmc_pkg::WINDOW_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input tick stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,   // motion, smoke, temperature[15:0], pad
	// Result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // motor_run, lockout_active,
	                                                     // fast_mode, led_colour[1:0], pad
	// Configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mtmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	mtmc_pkg::cfg_t cfg;
	mtmc_pkg::cmd_t cmd;
	mtmc_pkg::sts_t sts;

	logic       motor_run;
	logic       lockout_active;
	logic       fast_mode;
	logic [1:0] led_colour;

	// Register bank: the user must write it only between ticks; the bank does not enforce this
	mtmc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer: owns both handshakes and steps the datapath
	mtmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Timers, window, score unit and result register
	mtmc_datapath #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.motion         (s_tdata[0]),
		.smoke          (s_tdata[1]),
		.temperature    (s_tdata[17:2]),
		.motor_run      (motor_run),
		.lockout_active (lockout_active),
		.fast_mode      (fast_mode),
		.led_colour     (led_colour)
	);

	// Pack the result beat, lowest field first
	assign m_tdata = {3'b000, led_colour, fast_mode, lockout_active, motor_run};

`include "motion_triggered_motor_controller_macros.svh"

	// Never take a tick while an untaken result would be overwritten
	`MTMC_ASSERT_NOW(a_no_overwrite, s_tvalid && s_tready && m_tvalid, m_tready)
	// One tick in flight: ready drops right after a beat is taken
	`MTMC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// Lockout always stops the motor
	`MTMC_ASSERT_NOW(a_lockout_stops, m_tvalid && m_tdata[1], !m_tdata[0])
	// Fast mode and the red LED come from the same cold sample
	`MTMC_ASSERT_NOW(a_fast_is_red, m_tvalid && m_tdata[2], m_tdata[4:3] == mtmc_pkg::LED_RED)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import mtmc_pkg::*;

	localparam int WIN = WINDOW_LEN_DEF;
	// Integer score weights for the window, scaled so that no rounding occurs
	localparam longint unsigned W_MEAN  = 10 * WIN * (WIN - 1);
	localparam longint unsigned W_VAR   = 3 * (WIN + 1) * (WIN - 1);
	localparam longint unsigned W_TRANS = 2 * WIN * WIN * (WIN + 1);

	localparam logic [THR_W-1:0]     THRESH_HIGH = THR_W'(1236900);
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;  // no register behind it

	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 2 * (WIN + 6);

	typedef struct packed {
		logic motor_run;
		logic lockout_active;
		logic fast_mode;
		led_t led_colour;
	} status_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;  // motion, smoke, temperature[15:0], pad
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;         // motor_run, lockout_active, fast_mode,
	                                        // led_colour[1:0], pad
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Controller copy kept by the testbench
	cfg_t           regs;
	logic [WIN-1:0] window;       // bit 0 newest
	int             window_fill;
	logic [15:0]    lockout_left;
	logic [15:0]    run_left;
	logic [15:0]    predict_count;
	logic [15:0]    temp_count;
	logic           fast_flag;
	led_t           led_state;

	status_t expected_status[$];
	int      fail_count     = 0;
	int      cycles         = 0;
	int      src_idle_pct   = 0;
	int      sink_stall_pct = 0;

	motion_triggered_motor_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bail out if the DUT hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Sink throttling: drop ready for a random share of cycles
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// ------------------------------------------------------------------
	// Software controller
	// ------------------------------------------------------------------
	function automatic void reset_controller();
		regs.score_threshold = THRESH_RST;
		regs.run_ticks       = RUN_RST;
		regs.lockout_ticks   = LOCKOUT_RST;
		regs.predict_period  = PREDICT_RST;
		regs.temp_period     = TEMP_RST;
		regs.cold_limit      = COLD_RST;
		regs.hot_limit       = HOT_RST;
		window        = '0;
		window_fill   = 0;
		lockout_left  = '0;
		run_left      = '0;
		predict_count = '0;
		temp_count    = '0;
		fast_flag     = 1'b0;
		led_state     = LED_GREEN;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		case (idx)
			CFG_SCORE_THRESHOLD: regs.score_threshold = value[THR_W-1:0];
			CFG_RUN_TICKS:       regs.run_ticks       = value[CNT_W-1:0];
			CFG_LOCKOUT_TICKS:   regs.lockout_ticks   = value[CNT_W-1:0];
			CFG_PREDICT_PERIOD:  regs.predict_period  = value[CNT_W-1:0];
			CFG_TEMP_PERIOD:     regs.temp_period     = value[CNT_W-1:0];
			CFG_COLD_LIMIT:      regs.cold_limit      = value[CNT_W-1:0];
			CFG_HOT_LIMIT:       regs.hot_limit       = value[CNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Weighted occupancy, spread and flip count of the window, all in integers
	function automatic longint unsigned window_score(input logic [WIN-1:0] w);
		longint unsigned weighted;
		longint unsigned ones;
		longint unsigned flips;
		weighted = 0;
		ones     = 0;
		flips    = 0;
		for (int j = 0; j < WIN; j++) begin
			if (w[j]) begin
				weighted += WIN - j;
				ones++;
			end
			if (j + 1 < WIN && (w[j] != w[j+1]))
				flips++;
		end
		return W_MEAN * weighted + W_VAR * ones * (WIN - ones) + W_TRANS * flips;
	endfunction

	// Advance the controller by one tick and return the status it reports
	function automatic status_t step_controller(input logic motion, input logic smoke,
			input logic [15:0] temp);
		status_t         st;
		longint unsigned score;
		if (lockout_left != 0)
			lockout_left--;
		if (smoke) begin
			lockout_left = regs.lockout_ticks;
			run_left     = '0;
		end
		window = {window[WIN-2:0], motion};
		if (window_fill < WIN)
			window_fill++;

		temp_count++;
		if (temp_count >= regs.temp_period) begin
			temp_count = '0;
			fast_flag  = (temp < regs.cold_limit);
			if (temp < regs.cold_limit)
				led_state = LED_RED;
			else if (temp > regs.hot_limit)
				led_state = LED_BLUE;
			else
				led_state = LED_GREEN;
		end

		// Predictions are frozen during lockout
		if (lockout_left == 0) begin
			predict_count++;
			if (predict_count >= regs.predict_period) begin
				predict_count = '0;
				score = (window_fill >= WIN) ? window_score(window) : 0;
				if (score >= regs.score_threshold)
					run_left = regs.run_ticks;
			end
		end else begin
			predict_count = '0;
		end

		if (run_left != 0)
			run_left--;

		st.motor_run      = (run_left != 0) && (lockout_left == 0);
		st.lockout_active = (lockout_left != 0);
		st.fast_mode      = fast_flag;
		st.led_colour     = led_state;
		return st;
	endfunction

	// ------------------------------------------------------------------
	// Status checker: pop the oldest expectation on every accepted beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_status
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				$error("status beat with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_status.pop_front();
				if (m_tdata[0] !== want.motor_run) begin
					$error("motor_run: expected %0d, got %0d", want.motor_run, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[1] !== want.lockout_active) begin
					$error("lockout_active: expected %0d, got %0d",
						want.lockout_active, m_tdata[1]);
					fail_count++;
				end
				if (m_tdata[2] !== want.fast_mode) begin
					$error("fast_mode: expected %0d, got %0d", want.fast_mode, m_tdata[2]);
					fail_count++;
				end
				if (m_tdata[4:3] !== want.led_colour) begin
					$error("led_colour: expected %0d, got %0d",
						want.led_colour, m_tdata[4:3]);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------
	// Hold the source off until every expected status beat is back
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// Offer one tick beat, idling first at the source's rate, and predict it
	task automatic send_tick(input logic motion, input logic smoke, input logic [15:0] temp);
		status_t st;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, temp, smoke, motion};
		do
			@(posedge clk);
		while (!s_tready);
		st = step_controller(motion, smoke, temp);
		expected_status.push_back(st);
	endtask

	// Register write, only ever issued with the pipe drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		wait_results_done();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sometimes set the bits above a 16-bit register to prove they are ignored
	function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [15:0] v);
		logic [4:0] junk;
		junk = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd0;
		return {junk, v};
	endfunction

	function automatic logic [15:0] pick_count(input int top);
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 16'd0;
		if (r < 13)
			return 16'hffff;
		return 16'($urandom_range(top, 1));
	endfunction

	task automatic randomise_regs();
		int          r;
		logic [15:0] cold;
		logic [15:0] hot;
		int          hot_wide;
		r = $urandom_range(99);
		if (r < 10)
			write_reg(CFG_SCORE_THRESHOLD, '0);
		else if (r < 18)
			write_reg(CFG_SCORE_THRESHOLD, THRESH_HIGH);
		else if (r < 22)
			write_reg(CFG_SCORE_THRESHOLD, '1);
		else
			write_reg(CFG_SCORE_THRESHOLD, CFG_DATA_W'($urandom_range(1000000, 200000)));
		write_reg(CFG_RUN_TICKS, with_junk(pick_count(80)));
		write_reg(CFG_LOCKOUT_TICKS,
			with_junk(($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(40, 1))));
		// Mostly short periods so that predictions and samplings happen often
		write_reg(CFG_PREDICT_PERIOD,
			with_junk(($urandom_range(19) == 0) ? 16'hffff : 16'($urandom_range(30))));
		write_reg(CFG_TEMP_PERIOD,
			with_junk(($urandom_range(19) == 0) ? 16'hffff : 16'($urandom_range(20))));
		cold     = 16'($urandom_range(65535));
		hot_wide = int'(cold) + $urandom_range(2000);
		hot      = (hot_wide > 65535) ? 16'hffff : 16'(hot_wide);
		r = $urandom_range(99);
		if (r < 10) begin
			// swap so that the cold limit lies at or above the hot one
			write_reg(CFG_COLD_LIMIT, with_junk(hot));
			write_reg(CFG_HOT_LIMIT, with_junk(cold));
		end else if (r < 15) begin
			write_reg(CFG_COLD_LIMIT, '0);
			write_reg(CFG_HOT_LIMIT, 21'hffff);
		end else begin
			write_reg(CFG_COLD_LIMIT, with_junk(cold));
			write_reg(CFG_HOT_LIMIT, with_junk(hot));
		end
	endtask

	// Temperatures cluster around the two limits, with some from the whole range
	function automatic logic [15:0] pick_temperature();
		int r;
		int t;
		r = $urandom_range(99);
		if (r < 35)
			t = int'(regs.cold_limit) + $urandom_range(6) - 3;
		else if (r < 70)
			t = int'(regs.hot_limit) + $urandom_range(6) - 3;
		else
			return 16'($urandom_range(65535));
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		return 16'(t);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Corner cases straight after reset: window filling, LED boundaries,
	// lockout, zero lockout reload, crossed limits and zero periods
	task automatic test_directed();
		logic [15:0] temps[7];
		temps = '{16'd0, 16'hffff, 16'd99, 16'd100, 16'd150, 16'd200, 16'd201};
		write_reg(CFG_PREDICT_PERIOD, 21'd1);
		write_reg(CFG_TEMP_PERIOD, 21'd1);
		write_reg(CFG_SCORE_THRESHOLD, 21'd1);
		write_reg(CFG_RUN_TICKS, 21'd3);
		write_reg(CFG_LOCKOUT_TICKS, 21'd2);
		write_reg(CFG_COLD_LIMIT, 21'd100);
		write_reg(CFG_HOT_LIMIT, 21'd200);
		write_reg(CFG_UNUSED, '1);
		// No run until the window is full, then the score clears the threshold
		for (int i = 0; i < WIN; i++)
			send_tick(1'b1, 1'b0, temps[i % 7]);
		send_tick(1'b0, 1'b0, 16'd150);
		send_tick(1'b1, 1'b1, 16'd150);
		send_tick(1'b1, 1'b0, 16'd150);
		// Smoke with a zero reload: run cleared, no lockout
		write_reg(CFG_LOCKOUT_TICKS, 21'd0);
		send_tick(1'b1, 1'b1, 16'd150);
		// Cold limit above hot limit
		write_reg(CFG_COLD_LIMIT, 21'd300);
		write_reg(CFG_HOT_LIMIT, 21'd50);
		send_tick(1'b0, 1'b0, 16'd100);
		send_tick(1'b1, 1'b0, 16'd400);
		// Zero periods fire on every tick
		write_reg(CFG_PREDICT_PERIOD, 21'd0);
		write_reg(CFG_TEMP_PERIOD, 21'd0);
		send_tick(1'b0, 1'b0, 16'd10);
	endtask

	// A period lowered below the running count fires on the next tick
	task automatic test_period_change();
		write_reg(CFG_PREDICT_PERIOD, 21'd40);
		write_reg(CFG_TEMP_PERIOD, 21'd40);
		write_reg(CFG_SCORE_THRESHOLD, 21'd0);
		write_reg(CFG_RUN_TICKS, 21'd5);
		write_reg(CFG_COLD_LIMIT, 21'd1000);
		write_reg(CFG_HOT_LIMIT, 21'd2000);
		for (int i = 0; i < 10; i++)
			send_tick(1'(i), 1'b0, 16'd3000);
		write_reg(CFG_PREDICT_PERIOD, 21'd3);
		write_reg(CFG_TEMP_PERIOD, 21'd3);
		for (int i = 0; i < 3; i++)
			send_tick(1'b1, 1'b0, 16'd500);
	endtask

	// Random traffic: motion in bursts of steady level with some pure noise,
	// rare smoke, temperatures near the limits
	task automatic random_phase(input int n_ticks, input int src_pct, input int sink_pct);
		logic motion_level;
		int   burst_left;
		logic motion;
		logic smoke;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		randomise_regs();
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		motion_level   = 1'b0;
		burst_left     = 0;
		for (int i = 0; i < n_ticks; i++) begin
			if (burst_left == 0) begin
				motion_level = 1'($urandom_range(1));
				burst_left   = $urandom_range(12, 1);
			end
			burst_left--;
			motion = ($urandom_range(99) < 15) ? 1'($urandom_range(1)) : motion_level;
			smoke  = ($urandom_range(59) == 0);
			send_tick(motion, smoke, pick_temperature());
			// Let the pipe run dry once mid-phase
			if (i == n_ticks / 2)
				wait_results_done();
		end
		wait_results_done();
	endtask

	task automatic test_random_traffic();
		random_phase(500, 0, 0);
		random_phase(500, 66, 0);
		random_phase(500, 0, 66);
		random_phase(500, 21, 21);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
	endtask

	// Longest reloads and periods; the long lockout goes last since it
	// blocks predictions for the rest of the run
	task automatic test_counter_extremes();
		write_reg(CFG_SCORE_THRESHOLD, '0);
		write_reg(CFG_RUN_TICKS, 21'hffff);
		write_reg(CFG_PREDICT_PERIOD, 21'd1);
		write_reg(CFG_TEMP_PERIOD, 21'hffff);
		for (int i = 0; i < 3; i++)
			send_tick(1'b1, 1'b0, 16'hffff);
		write_reg(CFG_SCORE_THRESHOLD, '1);
		write_reg(CFG_PREDICT_PERIOD, 21'hffff);
		send_tick(1'b1, 1'b0, 16'd0);
		write_reg(CFG_LOCKOUT_TICKS, 21'hffff);
		send_tick(1'b1, 1'b1, 16'd0);
		for (int i = 0; i < 3; i++)
			send_tick(1'b0, 1'b0, 16'hffff);
	endtask

	initial begin
		reset_controller();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_period_change();
		test_random_traffic();
		test_counter_extremes();

		wait_results_done();
		// Watch a little longer for stray beats
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
